// File: hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; every other file of the block refers to it by scoped name.
`default_nettype none

package lkv_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int CAP_W           = 5;
   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   // lookup verdict handed from the match logic to the update logic
   typedef struct packed {
      logic hit;
      logic full;
   } lookup_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/lkv_lookup.sv
// Key match, free-slot search and victim select over all entries.
// Depends on lkv_pkg.
`default_nettype none

module lkv_lookup #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
   parameter int IW      = $clog2(ENTRIES),
   parameter int CW      = $clog2(ENTRIES + 1)
) (
   input  wire logic signed [lkv_pkg::KEY_W-1:0] key,
   input  wire logic signed [lkv_pkg::KEY_W-1:0] keys [ENTRIES],
   input  wire logic [ENTRIES-1:0]               valid,
   input  wire logic [IW-1:0]                    ranks [ENTRIES],
   input  wire logic [CW-1:0]                    count,
   input  wire logic [lkv_pkg::CAP_W-1:0]        capacity,
   output lkv_pkg::lookup_status_type            status,
   output logic [IW-1:0]                         hit_idx,
   output logic [IW-1:0]                         slot_idx
);

   localparam int CMP_W = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] eff_cap;
   logic [CW-1:0]    oldest_rank;
   logic             free_seen;
   logic [IW-1:0]    free_idx;
   logic [IW-1:0]    victim_idx;
   logic             hit_found;
   logic             is_full;

   // clamp capacity to 1..ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      is_full = (CMP_W'(count) >= eff_cap);
   end

   assign oldest_rank = count - CW'(1);

   always_comb begin
      hit_found  = 1'b0;
      hit_idx    = '0;
      free_seen  = 1'b0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid[i] && keys[i] == key && !hit_found) begin
            hit_found = 1'b1;
            hit_idx   = IW'(i);
         end
         if (!valid[i] && !free_seen) begin
            free_seen = 1'b1;
            free_idx  = IW'(i);
         end
         // ranks of valid entries are a permutation of 0..count-1
         if (valid[i] && CW'(ranks[i]) == oldest_rank) begin
            victim_idx = IW'(i);
         end
      end
      slot_idx = is_full ? victim_idx : free_idx;
   end

   assign status = '{hit: hit_found, full: is_full};

endmodule

`default_nettype wire

// File: hw/rtl/lkv_rank.sv
// Recency rank update: move one entry to the front, age those ahead of it.
// Depends on lkv_pkg.
`default_nettype none

module lkv_rank #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
   parameter int IW      = $clog2(ENTRIES),
   parameter int CW      = $clog2(ENTRIES + 1)
) (
   input  wire logic [IW-1:0]      ranks [ENTRIES],
   input  wire logic [ENTRIES-1:0] valid,
   input  wire logic [IW-1:0]      target,
   input  wire logic [CW-1:0]      pivot,
   output logic [IW-1:0]           ranks_next [ENTRIES]
);

   // pivot is the old rank of the target, or the count for a fresh insert
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (IW'(i) == target) begin
            ranks_next[i] = '0;
         end else if (valid[i] && CW'(ranks[i]) < pivot) begin
            ranks_next[i] = ranks[i] + IW'(1);
         end else begin
            ranks_next[i] = ranks[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_lookup and lkv_rank.
//
//   channel   ports                                     handshake
//   -------   ---------------------------------------   -----------------------------
//   request   req_operation, req_key, req_value         start high, busy low at edge
//   response  rsp_found, rsp_read_value                 rsp_valid strobe, one cycle
//   csr       csr_wdata (capacity in use)               csr_write high at edge
//
// One word is accepted every cycle; busy stays low. The accepting edge loads the
// request register; the next edge runs the match and rank logic, commits the
// table state and loads the response register, so a get's response stands in
// the cycle after that edge. The next word sees the committed table at once.
// Puts give no response. The receiver cannot stall: each response stands for
// exactly one cycle. Reset (synchronous) empties the cache and sets capacity to
// 16; a csr write empties it too. The user must have a csr write taken only while
// no word is in flight; the block itself does not enforce this.
`default_nettype none

module lru_key_value_cache_core #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_operation,
   input  wire logic signed [lkv_pkg::KEY_W-1:0]   req_key,
   input  wire logic signed [lkv_pkg::VALUE_W-1:0] req_value,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic signed [lkv_pkg::VALUE_W-1:0]      rsp_read_value,
   input  wire logic                              csr_write,
   input  wire logic [lkv_pkg::CAP_W-1:0]          csr_wdata
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   // request register
   logic                                  stage_valid_ff;
   lkv_pkg::op_type                       op_ff;
   logic signed [lkv_pkg::KEY_W-1:0]      key_ff;
   logic signed [lkv_pkg::VALUE_W-1:0]    value_ff;

   // table state
   logic signed [lkv_pkg::KEY_W-1:0]      keys_ff   [ENTRIES];
   logic signed [lkv_pkg::VALUE_W-1:0]    values_ff [ENTRIES];
   logic [ENTRIES-1:0]                    valid_ff, valid_in;
   logic [IW-1:0]                         ranks_ff  [ENTRIES];
   logic [IW-1:0]                         ranks_in  [ENTRIES];
   logic [CW-1:0]                         count_ff, count_in;
   logic [lkv_pkg::CAP_W-1:0]             cap_ff;

   // response register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  found_ff, found_in;
   logic signed [lkv_pkg::VALUE_W-1:0]    read_value_ff, read_value_in;

   // lookup and update wiring
   lkv_pkg::lookup_status_type            status;
   logic [IW-1:0]                         hit_idx;
   logic [IW-1:0]                         slot_idx;
   logic [IW-1:0]                         target;
   logic [CW-1:0]                         pivot;
   logic [IW-1:0]                         ranks_next [ENTRIES];
   logic                                  rank_en;
   logic                                  key_we;
   logic                                  value_we;

   assign busy = 1'b0;

   lkv_lookup #(
      .ENTRIES (ENTRIES),
      .IW      (IW),
      .CW      (CW)
   ) u_lookup (
      .key      (key_ff),
      .keys     (keys_ff),
      .valid    (valid_ff),
      .ranks    (ranks_ff),
      .count    (count_ff),
      .capacity (cap_ff),
      .status   (status),
      .hit_idx  (hit_idx),
      .slot_idx (slot_idx)
   );

   // a hit or an eviction touches an existing entry; otherwise a fresh insert
   // ages every valid entry, which is the same as a pivot equal to the count
   assign target = status.hit ? hit_idx : slot_idx;
   assign pivot  = (status.hit || status.full) ? CW'(ranks_ff[target]) : count_ff;

   lkv_rank #(
      .ENTRIES (ENTRIES),
      .IW      (IW),
      .CW      (CW)
   ) u_rank (
      .ranks      (ranks_ff),
      .valid      (valid_ff),
      .target     (target),
      .pivot      (pivot),
      .ranks_next (ranks_next)
   );

   always_comb begin
      valid_in      = valid_ff;
      count_in      = count_ff;
      ranks_in      = ranks_ff;
      rank_en       = 1'b0;
      key_we        = 1'b0;
      value_we      = 1'b0;
      rsp_valid_in  = 1'b0;
      found_in      = 1'b0;
      read_value_in = '0;
      if (stage_valid_ff) begin
         case (op_ff)
            lkv_pkg::OP_GET: begin
               rsp_valid_in = 1'b1;
               if (status.hit) begin
                  rank_en       = 1'b1;
                  found_in      = 1'b1;
                  read_value_in = values_ff[hit_idx];
               end
            end
            lkv_pkg::OP_PUT: begin
               rank_en  = 1'b1;
               value_we = 1'b1;
               if (!status.hit) begin
                  key_we = 1'b1;
                  if (!status.full) begin
                     valid_in[slot_idx] = 1'b1;
                     count_in           = count_ff + CW'(1);
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
      if (rank_en) begin
         ranks_in = ranks_next;
      end
   end

   // control state; a csr write wins over a word in flight and empties the table
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         valid_ff       <= '0;
         count_ff       <= '0;
         cap_ff         <= lkv_pkg::CAP_RESET;
      end else begin
         stage_valid_ff <= start && !busy;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write) begin
            valid_ff <= '0;
            count_ff <= '0;
            cap_ff   <= csr_wdata;
         end else begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
      end
   end

   // payload: request word, ranks, response word
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff    <= lkv_pkg::op_type'(req_operation);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      ranks_ff      <= ranks_in;
      found_ff      <= found_in;
      read_value_ff <= read_value_in;
   end

   // key and value stores: one write port each at the chosen slot
   always_ff @(posedge clock) begin
      if (key_we) begin
         keys_ff[slot_idx] <= key_ff;
      end
      if (value_we) begin
         values_ff[target] <= value_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_read_value = read_value_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lkv_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkv_pkg and on lru_key_value_cache_core's port list only.
`default_nettype none

module lkv_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              req_operation,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_found,
   input wire logic signed [lkv_pkg::VALUE_W-1:0] rsp_read_value,
   input wire logic                              csr_write
);

   // every response traces back to an accepted get
   a_rsp_from_get: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !req_operation, 2))
      else $error("response without a matching get");

   // every accepted get yields a response
   a_get_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_operation) ##1 1'b1 |=> rsp_valid)
      else $error("get accepted but no response");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_read_value == '0))
      else $error("miss response carries a nonzero value");

   // a get right after a csr write (with no word accepted alongside it) always misses
   a_cleared_miss: assert property (@(posedge clock) disable iff (reset)
      (csr_write && !(start && !busy))
         ##1 (start && !busy && !req_operation && !csr_write)
         |=> ##1 (rsp_valid && !rsp_found))
      else $error("hit after the table was emptied");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_found      (rsp_found),
   .rsp_read_value (rsp_read_value),
   .csr_write      (csr_write)
);

`default_nettype wire
